@@ rtl/pes_pkg.sv @@
package pes_pkg;

  // Per-PID store depth and transport packet length
  localparam int unsigned PID_COUNT    = 8192;
  localparam int unsigned PACKET_BYTES = 188;

  // Field widths
  localparam int unsigned PID_W     = 13;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PID_IDX_W = (PID_COUNT > 1) ? $clog2(PID_COUNT) : 1;

  // Payload bytes at or beyond this packet index are never passed
  localparam logic [BYTE_W-1:0] PAYLOAD_LIMIT = BYTE_W'(PACKET_BYTES - 4);
  // Fixed part of the PES header ahead of the optional header bytes
  localparam logic [BYTE_W:0]   HDR_BASE      = 9'd9;
  localparam logic [BYTE_W-1:0] IDX_MAX       = 8'hFF;

  // Byte positions inside a unit-start packet
  localparam logic [BYTE_W-1:0] IDX_SC0     = 8'd0;
  localparam logic [BYTE_W-1:0] IDX_SC1     = 8'd1;
  localparam logic [BYTE_W-1:0] IDX_SC2     = 8'd2;
  localparam logic [BYTE_W-1:0] IDX_STREAM  = 8'd3;
  localparam logic [BYTE_W-1:0] IDX_HDR_LEN = 8'd8;
  localparam logic [BYTE_W-1:0] IDX_HDR_END = 8'd9;

  // Start code bytes
  localparam logic [BYTE_W-1:0] SC_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] SC_ONE  = 8'h01;

  // Stream ids that carry no elementary stream bytes in the start packet
  localparam logic [BYTE_W-1:0] SID_PROG_MAP   = 8'hBC;
  localparam logic [BYTE_W-1:0] SID_PADDING    = 8'hBE;
  localparam logic [BYTE_W-1:0] SID_PRIVATE_2  = 8'hBF;
  localparam logic [BYTE_W-1:0] SID_ECM        = 8'hF0;
  localparam logic [BYTE_W-1:0] SID_EMM        = 8'hF1;
  localparam logic [BYTE_W-1:0] SID_DIRECTORY  = 8'hFF;
  localparam logic [BYTE_W-1:0] SID_DSMCC      = 8'hF2;
  localparam logic [BYTE_W-1:0] SID_H222_E     = 8'hF8;

  // Command queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Work the back end performs against the per-PID bits
  typedef enum logic [2:0] {
    OP_FLAG,         // report only the bad start flag
    OP_COND_PASS,    // pass byte if the PID is started
    OP_PASS,         // pass byte unconditionally
    OP_UNIT_START,   // close the pending unit of the PID
    OP_SET_STARTED   // mark the PID started
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              bad;
    logic [PID_W-1:0]  pid;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic [PID_W-1:0]  out_pid;
    logic              unit_end;
    logic              bad_start;
  } result_t;

  function automatic logic is_special_id(input logic [BYTE_W-1:0] id);
    return (id == SID_PROG_MAP)  || (id == SID_PADDING) || (id == SID_PRIVATE_2) ||
           (id == SID_ECM)       || (id == SID_EMM)     || (id == SID_DIRECTORY) ||
           (id == SID_DSMCC)     || (id == SID_H222_E);
  endfunction

endpackage

@@ rtl/pes_intf.sv @@
interface pes_in_if;
  logic                          valid;
  logic                          ready;
  logic [pes_pkg::PID_W-1:0]     in_pid;
  logic                          unit_start;
  logic                          first_byte;
  logic                          last_byte;
  logic [pes_pkg::BYTE_W-1:0]    data_byte;

  modport source (output valid, in_pid, unit_start, first_byte, last_byte, data_byte,
                  input ready);
  modport sink   (input valid, in_pid, unit_start, first_byte, last_byte, data_byte,
                  output ready);
endinterface

interface pes_out_if;
  logic                          valid;
  logic                          ready;
  logic                          out_valid;
  logic [pes_pkg::BYTE_W-1:0]    out_byte;
  logic [pes_pkg::PID_W-1:0]     out_pid;
  logic                          unit_end;
  logic                          bad_start;

  modport source (output valid, out_valid, out_byte, out_pid, unit_end, bad_start,
                  input ready);
  modport sink   (input valid, out_valid, out_byte, out_pid, unit_end, bad_start,
                  output ready);
endinterface

@@ rtl/pes_front.sv @@
module pes_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  pes_in_if.sink         in_i,
  input  logic           clr_busy_i,
  input  logic           full_i,
  output logic           push_o,
  output pes_pkg::cmd_t  cmd_o
);
  import pes_pkg::*;

  logic [BYTE_W-1:0] bi_q, bi_d;
  logic              ps_q, ps_d;
  logic              sc_q, sc_d;
  logic              ord_q, ord_d;
  logic [BYTE_W-1:0] hl_q, hl_d;

  logic              fire;
  logic              in_range;
  logic              ps;
  logic              sc_ok;
  logic [BYTE_W-1:0] idx;

  // Hold off new bytes while the PID store is cleared or the queue is full
  assign in_i.ready = !clr_busy_i && !full_i;
  assign fire       = in_i.valid && in_i.ready;
  assign in_range   = {1'b0, in_i.in_pid} < (PID_W + 1)'(PID_COUNT);
  assign idx        = in_i.first_byte ? IDX_SC0 : bi_q;

  // Track the packet position and classify the byte
  always_comb begin
    bi_d   = bi_q;
    ps_d   = ps_q;
    sc_d   = sc_q;
    ord_d  = ord_q;
    hl_d   = hl_q;
    ps     = ps_q;
    sc_ok  = 1'b0;
    push_o = 1'b0;
    cmd_o.op   = OP_FLAG;
    cmd_o.bad  = 1'b0;
    cmd_o.pid  = in_i.in_pid;
    cmd_o.data = in_i.data_byte;
    if (fire && in_range) begin
      if (in_i.first_byte) begin
        ps = in_i.unit_start;
      end
      bi_d = (idx < IDX_MAX) ? idx + 8'd1 : IDX_MAX;
      if (!in_i.unit_start) begin
        if (idx < PAYLOAD_LIMIT) begin
          cmd_o.op = OP_COND_PASS;
          push_o   = 1'b1;
        end
      end else if (ps) begin
        if (idx == IDX_SC0) begin
          cmd_o.op = OP_UNIT_START;
          push_o   = 1'b1;
          sc_d     = (in_i.data_byte == SC_ZERO);
          ord_d    = 1'b0;
          hl_d     = '0;
        end else if (idx == IDX_SC1) begin
          sc_d = sc_q && (in_i.data_byte == SC_ZERO);
        end else if (idx == IDX_SC2) begin
          sc_ok = sc_q && (in_i.data_byte == SC_ONE);
          sc_d  = sc_ok;
          if (sc_ok) begin
            cmd_o.op = OP_SET_STARTED;
            push_o   = 1'b1;
          end else begin
            cmd_o.bad = 1'b1;
          end
        end else if (idx == IDX_STREAM) begin
          ord_d = sc_q && !is_special_id(in_i.data_byte);
        end else if (idx == IDX_HDR_LEN) begin
          hl_d = in_i.data_byte;
        end else if (idx >= IDX_HDR_END && sc_q && ord_q &&
                     {1'b0, idx} >= HDR_BASE + {1'b0, hl_q} &&
                     idx < PAYLOAD_LIMIT) begin
          cmd_o.op = OP_PASS;
          push_o   = 1'b1;
        end
        // A unit-start packet that ends inside the start code is bad
        if (in_i.last_byte && idx < IDX_SC2) begin
          cmd_o.bad = 1'b1;
        end
        if (cmd_o.bad) begin
          push_o = 1'b1;
        end
      end
      ps_d = in_i.last_byte ? 1'b0 : ps;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bi_q  <= '0;
      ps_q  <= 1'b0;
      sc_q  <= 1'b0;
      ord_q <= 1'b0;
      hl_q  <= '0;
    end else begin
      bi_q  <= bi_d;
      ps_q  <= ps_d;
      sc_q  <= sc_d;
      ord_q <= ord_d;
      hl_q  <= hl_d;
    end
  end

  // A command that only flags must carry the flag
  a_flag_cmd_has_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && cmd_o.op == OP_FLAG |-> cmd_o.bad)
    else $error("flag-only command pushed without bad start");

endmodule

@@ rtl/pes_fifo.sv @@
module pes_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pes_pkg::cmd_t  cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output pes_pkg::cmd_t  head_o
);
  import pes_pkg::*;

  cmd_t                  slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d;
  logic [FIFO_PTR_W-1:0] rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full_o |-> pop_i)
    else $error("command pushed into a full queue");

endmodule

@@ rtl/pes_back.sv @@
module pes_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  pes_pkg::cmd_t  head_i,
  output logic           pop_o,
  output logic           clr_busy_o,
  pes_out_if.source      out_o
);
  import pes_pkg::*;

  // Per-PID bits: [1] started, [0] pending
  logic [1:0]           mem [PID_COUNT];
  logic [1:0]           rd_q;
  logic                 mem_we;
  logic [PID_IDX_W-1:0] mem_wa;
  logic [1:0]           mem_wd;

  logic                 clr_q, clr_d;
  logic [PID_IDX_W-1:0] clr_addr_q, clr_addr_d;

  logic                 s2_valid_q, s2_valid_d;
  cmd_t                 s2_q;
  logic                 fwd_q;
  logic [1:0]           fwd_data_q;

  result_t              out_q;
  logic                 out_vld_q, out_vld_d;

  logic                 take;
  logic                 s2_adv;
  logic                 fwd_hit;
  logic [1:0]           cur;
  logic [1:0]           nxt;
  result_t              res;
  logic                 emit;

  assign clr_busy_o = clr_q;
  assign s2_adv     = s2_valid_q && (!out_vld_q || out_o.ready);
  assign take       = !clr_q && head_valid_i && (!s2_valid_q || s2_adv);
  assign pop_o      = take;
  assign cur        = fwd_q ? fwd_data_q : rd_q;

  // Apply the command to the PID bits and build the result
  always_comb begin
    nxt           = cur;
    res.out_valid = 1'b0;
    res.out_byte  = '0;
    res.out_pid   = s2_q.pid;
    res.unit_end  = 1'b0;
    res.bad_start = s2_q.bad;
    case (s2_q.op)
      OP_COND_PASS: begin
        if (cur[1]) begin
          res.out_valid = 1'b1;
          nxt[0]        = 1'b1;
        end
      end
      OP_PASS: begin
        res.out_valid = 1'b1;
        nxt[0]        = 1'b1;
      end
      OP_UNIT_START: begin
        res.unit_end = cur[0];
        nxt[0]       = 1'b0;
      end
      OP_SET_STARTED: begin
        nxt[1] = 1'b1;
      end
      default: begin
        nxt = cur;
      end
    endcase
    if (res.out_valid) begin
      res.out_byte = s2_q.data;
    end
    emit = res.out_valid || res.unit_end || res.bad_start;
  end

  // Write port: clearing sweep after reset, then write-back of the stage
  always_comb begin
    if (clr_q) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_q;
      mem_wd = '0;
    end else begin
      mem_we = s2_adv;
      mem_wa = s2_q.pid[PID_IDX_W-1:0];
      mem_wd = nxt;
    end
  end

  // Bypass a write-back to the same PID being read this cycle
  assign fwd_hit = s2_adv && (s2_q.pid == head_i.pid);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (take) begin
      rd_q <= mem[head_i.pid[PID_IDX_W-1:0]];
    end
  end

  // Next control state
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == PID_IDX_W'(PID_COUNT - 1)) begin
        clr_d = 1'b0;
      end
    end
    s2_valid_d = s2_valid_q;
    if (take) begin
      s2_valid_d = 1'b1;
    end else if (s2_adv) begin
      s2_valid_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (s2_adv) begin
      out_vld_d = emit;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      s2_valid_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      s2_valid_q <= s2_valid_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Stage and output payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      s2_q       <= head_i;
      fwd_q      <= fwd_hit;
      fwd_data_q <= nxt;
    end
    if (s2_adv) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_valid = out_q.out_valid;
  assign out_o.out_byte  = out_q.out_byte;
  assign out_o.out_pid   = out_q.out_pid;
  assign out_o.unit_end  = out_q.unit_end;
  assign out_o.bad_start = out_q.bad_start;

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !take)
    else $error("command taken during PID store clear");

  a_result_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.out_valid || out_q.unit_end || out_q.bad_start))
    else $error("empty result presented");

endmodule

@@ rtl/pes_payload_extractor.sv @@
// PES payload extractor: takes transport packet payload bytes one per transaction,
// tagged with PID and packet marks, and returns elementary stream bytes, unit-end
// and bad-start-code reports. One byte per clock is sustained unless the queue fills
// or the output stalls; a byte passes the queue, stage and output registers. The front
// tracks the packet position and start code and pushes one command per relevant byte
// into a four-entry queue; the back reads the PID's started/pending bits from a store
// with one registered read port and one write port, writes them back from the stage,
// and bypasses back-to-back commands on the same PID. After reset the store is cleared
// one entry per cycle, and no input transaction is taken until that sweep is done.
module pes_payload_extractor (
  input  logic      clk_i,
  input  logic      rst_ni,
  pes_in_if.sink    in_i,
  pes_out_if.source out_o
);
  import pes_pkg::*;

  logic clr_busy;
  logic full;
  logic push;
  cmd_t cmd;
  logic pop;
  logic head_valid;
  cmd_t head;

  pes_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .clr_busy_i (clr_busy),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  pes_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  pes_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .clr_busy_o   (clr_busy),
    .out_o        (out_o)
  );

endmodule

@@ tb/pes_payload_extractor_checker.sv @@
`timescale 1ns / 1ps

// Watch both channels, predict each result from the accepted bytes and compare
module pes_payload_extractor_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pes_in_if    byte_i,
  pes_out_if   result_i,
  output int   fail_count_o,
  output int   pending_o
);
  import pes_pkg::*;

  // Results still owed by the block, oldest first
  result_t expected_q[$];

  // Per-PID unit tracking
  bit pid_started[PID_COUNT];
  bit pid_pending[PID_COUNT];

  // Position and header state of the packet in progress
  logic [BYTE_W-1:0] pkt_idx;
  logic [BYTE_W-1:0] hdr_len;
  bit                code_ok;
  bit                ordinary_id;
  bit                in_start_pkt;
  int                fail_cnt;

  // Advance the extractor state by one payload byte; return 1 when it yields a result
  function automatic bit extract_byte(input logic [PID_W-1:0] pid, input logic us,
                                      input logic fb, input logic lb,
                                      input logic [BYTE_W-1:0] b, output result_t res);
    logic [BYTE_W-1:0] idx;
    bit pass = 1'b0;
    bit uend = 1'b0;
    bit bad  = 1'b0;
    bit special;
    res = '0;
    if (pid >= PID_COUNT) return 1'b0;

    idx = fb ? IDX_SC0 : pkt_idx;
    if (fb) in_start_pkt = us;
    pkt_idx = (idx < IDX_MAX) ? idx + 8'd1 : IDX_MAX;

    if (!us) begin
      // Continuation bytes below the payload limit pass once the PID has started
      if (pid_started[pid] && idx < PAYLOAD_LIMIT) begin
        pass = 1'b1;
        pid_pending[pid] = 1'b1;
      end
    end else if (in_start_pkt) begin
      if (idx == IDX_SC0) begin
        if (pid_pending[pid]) begin
          uend = 1'b1;
          pid_pending[pid] = 1'b0;
        end
        code_ok     = (b == SC_ZERO);
        ordinary_id = 1'b0;
        hdr_len     = '0;
      end else if (idx == IDX_SC1) begin
        code_ok = code_ok && (b == SC_ZERO);
      end else if (idx == IDX_SC2) begin
        code_ok = code_ok && (b == SC_ONE);
        if (code_ok) pid_started[pid] = 1'b1;
        else bad = 1'b1;
      end else if (idx == IDX_STREAM) begin
        case (b)
          SID_PROG_MAP, SID_PADDING, SID_PRIVATE_2, SID_ECM,
          SID_EMM, SID_DIRECTORY, SID_DSMCC, SID_H222_E: special = 1'b1;
          default: special = 1'b0;
        endcase
        ordinary_id = code_ok && !special;
      end else if (idx == IDX_HDR_LEN) begin
        hdr_len = b;
      end else if (idx >= IDX_HDR_END && code_ok && ordinary_id &&
                   {1'b0, idx} >= HDR_BASE + {1'b0, hdr_len} && idx < PAYLOAD_LIMIT) begin
        pass = 1'b1;
        pid_pending[pid] = 1'b1;
      end
      // Packet closed before the start code was complete
      if (lb && idx < IDX_SC2) bad = 1'b1;
    end

    if (lb) in_start_pkt = 1'b0;

    res.out_valid = pass;
    res.out_byte  = pass ? b : '0;
    res.out_pid   = pid;
    res.unit_end  = uend;
    res.bad_start = bad;
    return pass || uend || bad;
  endfunction

  // Compare accepted results, then predict from the accepted byte
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < PID_COUNT; i++) begin
        pid_started[i] = 1'b0;
        pid_pending[i] = 1'b0;
      end
      pkt_idx      = '0;
      hdr_len      = '0;
      code_ok      = 1'b0;
      ordinary_id  = 1'b0;
      in_start_pkt = 1'b0;
      fail_cnt     = 0;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        got.out_valid = result_i.out_valid;
        got.out_byte  = result_i.out_byte;
        got.out_pid   = result_i.out_pid;
        got.unit_end  = result_i.unit_end;
        got.bad_start = result_i.bad_start;
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: pid %0d byte %0h", got.out_pid,
                 got.out_byte);
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (got.out_valid !== want.out_valid) begin
            $error("out_valid: expected %0d, actual %0d", want.out_valid, got.out_valid);
            fail_cnt++;
          end
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
            fail_cnt++;
          end
          if (got.out_pid !== want.out_pid) begin
            $error("out_pid: expected %0d, actual %0d", want.out_pid, got.out_pid);
            fail_cnt++;
          end
          if (got.unit_end !== want.unit_end) begin
            $error("unit_end: expected %0d, actual %0d", want.unit_end, got.unit_end);
            fail_cnt++;
          end
          if (got.bad_start !== want.bad_start) begin
            $error("bad_start: expected %0d, actual %0d", want.bad_start, got.bad_start);
            fail_cnt++;
          end
        end
      end
      if (byte_i.valid && byte_i.ready) begin
        if (extract_byte(byte_i.in_pid, byte_i.unit_start, byte_i.first_byte,
                         byte_i.last_byte, byte_i.data_byte, want))
          expected_q.push_back(want);
      end
      fail_count_o <= fail_cnt;
      pending_o    <= expected_q.size();
    end
  end

endmodule

@@ tb/pes_payload_extractor_tb.sv @@
`timescale 1ns / 1ps

module pes_payload_extractor_tb;
  import pes_pkg::*;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  localparam int ITEM_TARGET  = 425;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int LIMIT_CYCLES = 100000;

  localparam logic [BYTE_W-1:0] SPECIAL_IDS[8] = '{SID_PROG_MAP, SID_PADDING,
    SID_PRIVATE_2, SID_ECM, SID_EMM, SID_DIRECTORY, SID_DSMCC, SID_H222_E};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int idle_pct = 18;
  bit hold_req = 1'b0;
  int sent     = 0;
  int fail_count;
  int pending;

  pes_in_if  in_ch();
  pes_out_if out_ch();

  pes_payload_extractor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  pes_payload_extractor_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (in_ch),
    .result_i     (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Offer one byte after a random idle gap and hold it until accepted
  task automatic send_byte(input logic [PID_W-1:0] pid, input logic us, input logic fb,
                           input logic lb, input logic [BYTE_W-1:0] b);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid      <= 1'b1;
    in_ch.in_pid     <= pid;
    in_ch.unit_start <= us;
    in_ch.first_byte <= fb;
    in_ch.last_byte  <= lb;
    in_ch.data_byte  <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  // Send one packet payload; the first/last marks can be dropped to break framing
  task automatic send_packet(input logic [PID_W-1:0] pid, input logic us,
                             input byte_q_t bytes, input bit drop_first,
                             input bit drop_last);
    foreach (bytes[i])
      send_byte(pid, us, (i == 0) && !drop_first,
                (i == bytes.size() - 1) && !drop_last, bytes[i]);
  endtask

  function automatic byte_q_t random_bytes(input int len);
    byte_q_t q;
    for (int i = 0; i < len; i++) q.push_back(BYTE_W'($urandom_range(255)));
    return q;
  endfunction

  // Build a unit-start payload: start code, stream id, header length, payload
  function automatic byte_q_t make_pes_start(input int len, input bit clean);
    byte_q_t q;
    int r;
    q = random_bytes(len);
    r = $urandom_range(99);
    if (len > 0) q[0] = SC_ZERO;
    if (len > 1) q[1] = SC_ZERO;
    if (len > 2) q[2] = SC_ONE;
    // corrupt the start code now and then
    if (!clean && r < 12) q[r % (len < 3 ? len : 3)] = BYTE_W'($urandom_range(255));
    if (len > 3) begin
      r = $urandom_range(99);
      if (!clean && r < 25) q[3] = SPECIAL_IDS[$urandom_range(7)];
      else if (r < 40) q[3] = BYTE_W'($urandom_range(8'hBB));
      else q[3] = BYTE_W'($urandom_range(8'hEF, 8'hC0));
    end
    if (len > 8) begin
      r = $urandom_range(99);
      if (clean || r < 60) q[8] = BYTE_W'($urandom_range(4));
      else if (r < 80) q[8] = BYTE_W'($urandom_range(255));
      else q[8] = BYTE_W'($urandom_range(40));
    end
    return q;
  endfunction

  // Result side: random stalls, plus one long hold-off to back the block up
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Byte side: reset, directed packets, then random packet traffic
  initial begin
    byte_q_t          pkt;
    logic [PID_W-1:0] pid_pool[6];
    logic [PID_W-1:0] pid;
    logic             us;
    int               len;
    int               r;
    int               pkt_no;
    bit               paused;
    in_ch.valid      = 1'b0;
    in_ch.in_pid     = '0;
    in_ch.unit_start = 1'b0;
    in_ch.first_byte = 1'b0;
    in_ch.last_byte  = 1'b0;
    in_ch.data_byte  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // continuation on a PID that has not started: dropped
    pkt = {8'h12, 8'h34};
    send_packet(13'd5, 1'b0, pkt, 1'b0, 1'b0);
    // good start code, ordinary stream, empty header: two bytes pass
    pkt = {8'h00, 8'h00, 8'h01, 8'hE0, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'hAA, 8'hBB};
    send_packet(13'd5, 1'b1, pkt, 1'b0, 1'b0);
    // one-byte start packet: closes the pending unit and flags a bad start code
    pkt = {8'h00};
    send_packet(13'd5, 1'b1, pkt, 1'b0, 1'b0);
    // started PID keeps passing continuation bytes
    pkt = {8'hFF};
    send_packet(13'd5, 1'b0, pkt, 1'b0, 1'b0);
    // unit-start byte with no first mark in front of it: ignored
    send_byte(13'd5, 1'b1, 1'b0, 1'b0, 8'h00);
    // special stream id: starts the PID but passes nothing
    pkt = {8'h00, 8'h00, 8'h01, SID_PROG_MAP, 8'h7F};
    send_packet(13'd8191, 1'b1, pkt, 1'b0, 1'b0);
    // wrong third start code byte
    pkt = {8'h00, 8'h00, 8'h02};
    send_packet(13'd0, 1'b1, pkt, 1'b0, 1'b0);
    pkt = {8'h00};
    send_packet(13'd8191, 1'b0, pkt, 1'b0, 1'b0);

    pid_pool[0] = '0;
    pid_pool[1] = '1;
    pid_pool[2] = 13'd5;
    for (int i = 3; i < 6; i++) pid_pool[i] = PID_W'($urandom_range(8191));

    pkt_no = 0;
    paused = 1'b0;
    while (sent < ITEM_TARGET) begin
      idle_pct = (sent >= 150 && sent < 250) ? 0 : 18;
      if (sent >= 300) hold_req = 1'b1;
      // let everything drain once mid-run
      if (!paused && sent >= 200) begin
        paused = 1'b1;
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk_i);
      end
      r = $urandom_range(99);
      if (pkt_no == 3) begin
        // runs past the payload limit and saturates the byte position
        pkt = make_pes_start(260, 1'b1);
        send_packet(pid_pool[1], 1'b1, pkt, 1'b0, 1'b0);
      end else if (r < 12) begin
        repeat ($urandom_range(4, 1))
          send_byte(PID_W'($urandom_range(8191)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)),
                    BYTE_W'($urandom_range(255)));
      end else begin
        pid = ($urandom_range(99) < 80) ? pid_pool[$urandom_range(5)]
                                        : PID_W'($urandom_range(8191));
        r = $urandom_range(99);
        if (r < 2) len = $urandom_range(200, 185);
        else if (r < 20) len = $urandom_range(3, 1);
        else len = $urandom_range(32, 4);
        us = ($urandom_range(99) < 45);
        pkt = us ? make_pes_start(len, 1'b0) : random_bytes(len);
        r = $urandom_range(99);
        send_packet(pid, us, pkt, r < 5, r >= 5 && r < 10);
      end
      pkt_no++;
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 20);
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ pes_payload_extractor.f @@
rtl/pes_pkg.sv
rtl/pes_intf.sv
rtl/pes_front.sv
rtl/pes_fifo.sv
rtl/pes_back.sv
rtl/pes_payload_extractor.sv
tb/pes_payload_extractor_checker.sv
tb/pes_payload_extractor_tb.sv
